@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset
`define VPA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication checked in the next cycle
`define VPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/vpa_pkg.sv @@
`timescale 1ns / 1ps
package vpa_pkg;
   localparam logic [2:0] ST_PLACED  = 3'd0;
   localparam logic [2:0] ST_NOFIT   = 3'd1;
   localparam logic [2:0] ST_FULL    = 3'd2;
   localparam logic [2:0] ST_NOJOB   = 3'd3;
   localparam logic [2:0] ST_RESTART = 3'd4;

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST  = 2'd1;
   localparam logic [1:0] FIT_WORST = 2'd2;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_RESTART = 1'b1;

   localparam int CSR_FIT_MODE = 0;
   localparam int CSR_MEM_SIZE = 1;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_BUSY    = 7'b0000010,
      S_RELEASE = 7'b0000100,
      S_CHOOSE  = 7'b0001000,
      S_PLACE   = 7'b0010000,
      S_SETTLE  = 7'b0100000,
      S_DONE    = 7'b1000000
   } state_type;
endpackage

@@ rtl/core/variable_partition_allocator.sv @@
`timescale 1ns / 1ps
// Variable-partition allocator. One request word is taken at a time. In the
// first cycle after reset the free row is loaded with one region of 1024 units
// and the request side is held off; that cycle plays the part of a restart.
// A restart request passes through settle, reload and finish (S_SETTLE,
// S_BUSY, S_DONE) after acceptance; its result word is then registered.
// A tick visits each busy region in turn: a surviving one counts down in
// place, an expiring one is found, merged into the free row and then shifted
// out of the busy row (the free row shifts too after a double merge). A final
// visit closes the busy walk. The free row is then scanned one slot a cycle.
// First fit stops the cycle after the first region that fits. A job that is
// absent, or refused for a full busy table or zero size, ends the scan at its
// first step. A job that fits is then placed, and every request finishes in
// the done state. The result word is held in its own output register. The
// next request can therefore be taken while that word still waits on the
// result side.
module variable_partition_allocator #(
   parameter int SLOTS     = 32,
   parameter int ADDR_BITS = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // op, has_job, job_id[7:0], job_size[12:0], job_time[7:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // status[2:0], start_addr[11:0], released_count[5:0],
                                    // free_regions[5:0], busy_regions[5:0], zero fill
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_wdata
);
   import vpa_pkg::*;

   localparam int FS = SLOTS + 1;
   localparam int CW = $clog2(FS + 1);
   localparam int BI = $clog2(SLOTS);
   localparam int FI = $clog2(FS);
   localparam int AW = ADDR_BITS;
   localparam logic [AW:0] MEM_MAX = (AW + 1)'(1) << AW;
   localparam logic [AW:0] BOOT_LEN = (1024 > (1 << AW)) ? MEM_MAX : (AW + 1)'(1024);

   // configuration
   logic [1:0]  fit_ff;
   logic [12:0] msize_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_ff <= FIT_FIRST; msize_ff <= 13'd1024;
      end else if (csr_we) begin
         if (csr_index == 1'(CSR_FIT_MODE)) fit_ff <= csr_wdata[1:0];
         else                              msize_ff <= csr_wdata;
      end
   end

   // request fields
   logic        op_ff, hj_ff;
   logic [12:0] jsize_ff;
   logic [7:0]  jtime_ff;

   state_type       st_ff, st_in;
   logic [BI:0]     bidx_ff, bidx_in;     // busy slot under visit
   logic [FI:0]     fidx_ff, fidx_in;     // free slot under scan
   logic [CW-1:0]   fcnt_ff, fcnt_in;
   logic [BI:0]     bcnt_ff, bcnt_in;
   logic [5:0]      rel_ff, rel_in;
   logic            pick_ok_ff, pick_ok_in;
   logic [FI-1:0]   pick_ff, pick_in;
   logic [AW:0]     gap_ff, gap_in;
   logic [2:0]      status_ff, status_in;
   logic [AW-1:0]   addr_ff, addr_in;
   logic            ovld_ff, ovld_in;
   logic            phase_ff, phase_in;   // release: merge then shift
   logic            dbl_ff, dbl_in;       // release joined both neighbours
   logic [39:0]     rdata_ff, rdata_in;
   logic [39:0]     res_word;
   logic            boot_ff;
   logic            req_take;

   // cell rows
   logic [SLOTS-1:0] b_vld, b_clr, b_shift, b_load, b_dec;
   logic [AW-1:0]    b_start [SLOTS];
   logic [AW:0]      b_len [SLOTS];
   logic [7:0]       b_time [SLOTS];
   logic [FS-1:0]    f_vld, f_clr, f_up, f_down, f_wr;
   logic [AW-1:0]    f_start [FS];
   logic [AW:0]      f_len [FS];
   logic [AW-1:0]    f_wstart [FS];
   logic [AW:0]      f_wlen [FS];

   logic [AW-1:0] ld_start;
   logic [AW:0]   ld_len;
   logic [7:0]    ld_time;

   for (genvar g = 0; g < SLOTS; g++) begin : g_busy
      vpa_busy_cell #(.ADDR_BITS(AW)) u_cell (
         .clock, .reset, .clr(b_clr[g]), .shift(b_shift[g]), .load(b_load[g]),
         .dec(b_dec[g]),
         .nb_vld  (g == SLOTS-1 ? 1'b0 : b_vld[(g+1)%SLOTS]),
         .nb_start(b_start[(g+1)%SLOTS]), .nb_len(b_len[(g+1)%SLOTS]),
         .nb_time (b_time[(g+1)%SLOTS]),
         .ld_start, .ld_len, .ld_time,
         .vld(b_vld[g]), .start(b_start[g]), .len(b_len[g]), .tleft(b_time[g]));
   end
   for (genvar g = 0; g < FS; g++) begin : g_free
      vpa_free_cell #(.ADDR_BITS(AW)) u_cell (
         .clock, .reset, .clr(f_clr[g]), .up(f_up[g]), .down(f_down[g]), .wr(f_wr[g]),
         .lo_vld  (g == 0 ? 1'b0 : f_vld[(g+FS-1)%FS]),
         .lo_start(f_start[(g+FS-1)%FS]), .lo_len(f_len[(g+FS-1)%FS]),
         .hi_vld  (g == FS-1 ? 1'b0 : f_vld[(g+1)%FS]),
         .hi_start(f_start[(g+1)%FS]), .hi_len(f_len[(g+1)%FS]),
         .wr_start(f_wstart[g]), .wr_len(f_wlen[g]),
         .vld(f_vld[g]), .start(f_start[g]), .len(f_len[g]));
   end

   // current busy slot and its release placement in the free row
   logic [BI-1:0] bsel;
   logic [AW-1:0] rs;
   logic [AW:0]   rl;
   logic [FS-1:0] le;          // free slot starts at or below the region
   logic [FI:0]   pos;
   logic          jp, jn;
   logic [AW:0]   prev_end, rel_end;
   logic [FI-1:0] pm1, pp;
   logic [AW:0]   fl_pick;
   logic [AW:0]   gap_k;
   logic          fits_k, better_k;
   logic [FI-1:0] fsel;

   assign bsel = bidx_ff[BI-1:0];
   assign rs   = b_start[bsel];
   assign rl   = b_len[bsel];
   always_comb begin
      pos = '0;
      for (int k = 0; k < FS; k++) begin
         le[k] = (FI+1)'(k) < (FI+1)'(fcnt_ff) && f_start[k] <= rs;
         if (le[k]) pos = (FI+1)'(k + 1);
      end
   end
   assign pm1      = FI'(pos - (FI+1)'(1));
   assign pp       = FI'(pos);
   assign prev_end = {1'b0, f_start[pm1]} + f_len[pm1];
   assign rel_end  = {1'b0, rs} + rl;
   assign jp = pos != '0 && prev_end == {1'b0, rs};
   assign jn = pos < (FI+1)'(fcnt_ff) && rel_end == {1'b0, f_start[pp]};

   assign fsel   = fidx_ff[FI-1:0];
   assign fits_k = f_len[fsel] >= jsize_ff;
   assign gap_k  = f_len[fsel] - jsize_ff[AW:0];
   assign fl_pick = f_len[pick_ff] - jsize_ff[AW:0];

   always_comb begin
      case (fit_ff)
         FIT_BEST:  better_k = !pick_ok_ff || gap_k < gap_ff;
         FIT_WORST: better_k = !pick_ok_ff || gap_k > gap_ff;
         default:   better_k = !pick_ok_ff;
      endcase
   end

   assign ld_start = f_start[pick_ff];
   assign ld_len   = jsize_ff[AW:0];
   assign ld_time  = jtime_ff == 8'd0 ? 8'd1 : jtime_ff;

   // result word as it stands once a request has finished
   assign res_word = {7'b0, 6'(bcnt_ff), 6'(fcnt_ff),
                      (status_ff == ST_RESTART ? 6'd0 : rel_ff), 12'(addr_ff), status_ff};

   // sequencer
   always_comb begin
      st_in = st_ff; bidx_in = bidx_ff; fidx_in = fidx_ff; fcnt_in = fcnt_ff;
      bcnt_in = bcnt_ff; rel_in = rel_ff; pick_ok_in = pick_ok_ff; pick_in = pick_ff;
      gap_in = gap_ff; status_in = status_ff; addr_in = addr_ff; ovld_in = ovld_ff;
      phase_in = phase_ff; dbl_in = dbl_ff; rdata_in = rdata_ff;
      b_clr = '0; b_shift = '0; b_load = '0; b_dec = '0;
      f_clr = '0; f_up = '0; f_down = '0; f_wr = '0;
      for (int k = 0; k < FS; k++) begin
         f_wstart[k] = f_start[k]; f_wlen[k] = f_len[k];
      end
      if (ovld_ff && rsp_tready) ovld_in = 1'b0;
      case (st_ff)
         S_IDLE: begin
            if (boot_ff) begin
               // reset table: one free region of the default size
               f_wr[0] = 1'b1; f_wstart[0] = '0; f_wlen[0] = BOOT_LEN;
               fcnt_in = CW'(1);
            end else if (req_tvalid) begin
               bidx_in = '0; rel_in = '0; phase_in = 1'b0;
               st_in = req_tdata[0] == OP_RESTART ? S_SETTLE : S_BUSY;
            end
         end
         S_BUSY: begin
            if (op_ff == OP_RESTART) begin
               b_clr = '1; f_clr = '1; bcnt_in = '0;
               if (msize_ff != 13'd0) begin
                  f_clr[0] = 1'b0; f_wr[0] = 1'b1; f_wstart[0] = '0;
                  f_wlen[0] = msize_ff > 13'(MEM_MAX) ? MEM_MAX : msize_ff[AW:0];
                  fcnt_in = CW'(1);
               end else fcnt_in = '0;
               status_in = ST_RESTART; addr_in = '0; st_in = S_DONE;
            end else if (bidx_ff >= bcnt_ff) begin
               fidx_in = '0; pick_ok_in = 1'b0; st_in = S_CHOOSE;
            end else if (b_time[bsel] == 8'd1) begin
               st_in = S_RELEASE;
            end else begin
               b_dec[bsel] = 1'b1; bidx_in = bidx_ff + 1'b1;
            end
         end
         S_RELEASE: begin
            if (!phase_ff) begin
               // merge into the free row
               dbl_in = jp && jn;
               if (jp && jn) begin
                  f_wr[pm1] = 1'b1; f_wlen[pm1] = f_len[pm1] + rl + f_len[pp];
               end else if (jp) begin
                  f_wr[pm1] = 1'b1; f_wlen[pm1] = f_len[pm1] + rl;
               end else if (jn) begin
                  f_wr[pp] = 1'b1; f_wstart[pp] = rs; f_wlen[pp] = f_len[pp] + rl;
               end else if ((FI+1)'(fcnt_ff) < (FI+1)'(FS)) begin
                  f_wr[pp] = 1'b1; f_wstart[pp] = rs; f_wlen[pp] = rl;
                  for (int k = 0; k < FS; k++)
                     if ((FI+1)'(k) > pos && (FI+1)'(k) <= (FI+1)'(fcnt_ff)) f_up[k] = 1'b1;
                  fcnt_in = fcnt_ff + 1'b1;
               end
               rel_in = rel_ff + 1'b1; phase_in = 1'b1;
            end else begin
               // close the gaps: free row after a double merge, busy row always
               if (dbl_ff) begin
                  for (int k = 0; k < FS; k++)
                     if ((FI+1)'(k) >= pos) f_down[k] = 1'b1;
                  fcnt_in = fcnt_ff - 1'b1;
               end
               for (int k = 0; k < SLOTS; k++)
                  if ((BI+1)'(k) >= bidx_ff) b_shift[k] = 1'b1;
               bcnt_in = bcnt_ff - 1'b1; phase_in = 1'b0; st_in = S_BUSY;
            end
         end
         S_CHOOSE: begin
            if (!hj_ff) begin
               status_in = ST_NOJOB; addr_in = '0; st_in = S_DONE;
            end else if (bcnt_ff >= (BI+1)'(SLOTS)) begin
               status_in = ST_FULL; addr_in = '0; st_in = S_DONE;
            end else if (jsize_ff == 13'd0) begin
               status_in = ST_NOFIT; addr_in = '0; st_in = S_DONE;
            end else if (fidx_ff >= (FI+1)'(fcnt_ff) ||
                         (pick_ok_ff && fit_ff != FIT_BEST && fit_ff != FIT_WORST)) begin
               st_in = pick_ok_ff ? S_PLACE : S_DONE;
               status_in = ST_NOFIT; addr_in = '0;
            end else begin
               if (fits_k && better_k) begin
                  pick_ok_in = 1'b1; pick_in = fsel; gap_in = gap_k;
               end
               fidx_in = fidx_ff + 1'b1;
            end
         end
         S_PLACE: begin
            b_load[bcnt_ff[BI-1:0]] = 1'b1; bcnt_in = bcnt_ff + 1'b1;
            addr_in = f_start[pick_ff]; status_in = ST_PLACED;
            if (fl_pick == '0) begin
               for (int k = 0; k < FS; k++)
                  if ((FI+1)'(k) >= (FI+1)'(pick_ff)) f_down[k] = 1'b1;
               fcnt_in = fcnt_ff - 1'b1;
            end else begin
               f_wr[pick_ff] = 1'b1;
               f_wstart[pick_ff] = f_start[pick_ff] + jsize_ff[AW-1:0];
               f_wlen[pick_ff] = fl_pick;
            end
            st_in = S_DONE;
         end
         S_SETTLE: st_in = S_BUSY;
         S_DONE: begin
            // hand the word over once the output register is free
            if (!ovld_ff || rsp_tready) begin
               ovld_in = 1'b1; rdata_in = res_word; st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ovld_ff <= 1'b0; fcnt_ff <= '0; bcnt_ff <= '0;
         phase_ff <= 1'b0; op_ff <= OP_RESTART;
      end else begin
         st_ff <= st_in; ovld_ff <= ovld_in; fcnt_ff <= fcnt_in; bcnt_ff <= bcnt_in;
         phase_ff <= phase_in;
         if (req_take) op_ff <= req_tdata[0];
      end
      bidx_ff <= bidx_in; fidx_ff <= fidx_in; rel_ff <= rel_in;
      pick_ok_ff <= pick_ok_in; pick_ff <= pick_in; gap_ff <= gap_in;
      status_ff <= status_in; addr_ff <= addr_in; dbl_ff <= dbl_in;
      rdata_ff <= rdata_in;
      if (req_take) begin
         hj_ff <= req_tdata[1]; jsize_ff <= req_tdata[22:10]; jtime_ff <= req_tdata[30:23];
      end
   end

   // first cycle after reset: load the default table, input held off
   always_ff @(posedge clock) begin
      if (reset) boot_ff <= 1'b1;
      else if (st_ff == S_IDLE && boot_ff) boot_ff <= 1'b0;
   end

   assign req_tready = st_ff == S_IDLE && !boot_ff;
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = ovld_ff;
   assign rsp_tdata  = rdata_ff;

   `include "assert_macros.svh"
   `VPA_ASSERT(a_cnt_free, fcnt_ff <= CW'(FS), "free count overflow")
   `VPA_ASSERT(a_cnt_busy, bcnt_ff <= (BI+1)'(SLOTS), "busy count overflow")
   `VPA_ASSERT_NEXT(a_done, st_ff == S_DONE, rsp_tvalid, "result not raised")
endmodule

@@ rtl/core/vpa_busy_cell.sv @@
`timescale 1ns / 1ps
// One busy-table slot; the row shifts towards slot 0 one step a cycle while shift is raised.
module vpa_busy_cell #(
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clr,
   input  logic                 shift,       // take the neighbour's word
   input  logic                 load,        // take the new job word
   input  logic                 dec,         // count down in place
   input  logic                 nb_vld,
   input  logic [ADDR_BITS-1:0] nb_start,
   input  logic [ADDR_BITS:0]   nb_len,
   input  logic [7:0]           nb_time,
   input  logic [ADDR_BITS-1:0] ld_start,
   input  logic [ADDR_BITS:0]   ld_len,
   input  logic [7:0]           ld_time,
   output logic                 vld,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS:0]   len,
   output logic [7:0]           tleft
);
   logic                 vld_ff, vld_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS:0]   len_ff, len_in;
   logic [7:0]           time_ff, time_in;

   // next word of the slot
   always_comb begin
      vld_in = vld_ff; start_in = start_ff; len_in = len_ff; time_in = time_ff;
      if (clr) begin
         vld_in = 1'b0;
      end else if (load) begin
         vld_in = 1'b1; start_in = ld_start; len_in = ld_len; time_in = ld_time;
      end else if (shift) begin
         vld_in = nb_vld; start_in = nb_start; len_in = nb_len; time_in = nb_time;
      end else if (dec) begin
         time_in = time_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
      start_ff <= start_in;
      len_ff   <= len_in;
      time_ff  <= time_in;
   end

   assign vld = vld_ff; assign start = start_ff; assign len = len_ff; assign tleft = time_ff;
endmodule

@@ rtl/core/vpa_free_cell.sv @@
`timescale 1ns / 1ps
// One free-table slot; insertions shift the row up, removals shift it down.
module vpa_free_cell #(
   parameter int ADDR_BITS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 clr,
   input  logic                 up,          // take lower neighbour's word
   input  logic                 down,        // take upper neighbour's word
   input  logic                 wr,          // direct write
   input  logic                 lo_vld,
   input  logic [ADDR_BITS-1:0] lo_start,
   input  logic [ADDR_BITS:0]   lo_len,
   input  logic                 hi_vld,
   input  logic [ADDR_BITS-1:0] hi_start,
   input  logic [ADDR_BITS:0]   hi_len,
   input  logic [ADDR_BITS-1:0] wr_start,
   input  logic [ADDR_BITS:0]   wr_len,
   output logic                 vld,
   output logic [ADDR_BITS-1:0] start,
   output logic [ADDR_BITS:0]   len
);
   logic                 vld_ff, vld_in;
   logic [ADDR_BITS-1:0] start_ff, start_in;
   logic [ADDR_BITS:0]   len_ff, len_in;

   always_comb begin
      vld_in = vld_ff; start_in = start_ff; len_in = len_ff;
      if (clr) begin
         vld_in = 1'b0;
      end else if (wr) begin
         vld_in = 1'b1; start_in = wr_start; len_in = wr_len;
      end else if (up) begin
         vld_in = lo_vld; start_in = lo_start; len_in = lo_len;
      end else if (down) begin
         vld_in = hi_vld; start_in = hi_start; len_in = hi_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else       vld_ff <= vld_in;
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign vld = vld_ff; assign start = start_ff; assign len = len_ff;
endmodule
